/* hdl/tag_line_link_receiver_core_macros.svh */
// assertion macros for the tag line link receiver
`ifndef TAG_LINE_LINK_RECEIVER_CORE_MACROS_SVH
`define TAG_LINE_LINK_RECEIVER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TLLR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tllr check failed");
// next-cycle implication
`define TLLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tllr check failed");
`else
`define TLLR_ASSERT_NOW(label, clk, rst, ante, cons)
`define TLLR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/tllr_pkg.sv */
`default_nettype none
package tllr_pkg;

   localparam int ID_WIDTH = 32;
   localparam int SID_WIDTH = 32;

   localparam logic [7:0] CH_PROMPT = 8'h3E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_F  = 8'h66;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_STATUS = 2'd1,
      ERR_DATA   = 2'd2
   } line_error_type;

   typedef struct packed {
      logic                 byte_valid;
      logic [7:0]           byte_value;
      logic                 link_up;
      logic [SID_WIDTH-1:0] session_id;
      logic                 session_reset;
      line_error_type       line_error;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_char;
   } held_item_type;

   // {digit ok, nibble} for a lower-case hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd0;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            hex_digit = {1'b1, d[3:0]};
         end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            d = c - CH_LOW_A + 8'd10;
            hex_digit = {1'b1, d[3:0]};
         end else begin
            hex_digit = 5'd0;
         end
      end
   endfunction

endpackage
`default_nettype wire

/* hdl/tag_line_link_receiver_core.sv */
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_rx_char
//  rsp      out        rsp_valid/stall    byte, link state, session id, error
//
//  one character per cycle unless rsp_stall holds a full result register;
//  characters pass the input register, then parse logic to the result register
//  reset (synchronous, active high) leaves the parser at line start, link down
//  req_stall rises only while the result register is full and rsp_stall is high
//  every accepted transaction produces exactly one rsp transaction
`default_nettype none
`include "tag_line_link_receiver_core_macros.svh"
module tag_line_link_receiver_core
   import tllr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_rx_char,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_byte_valid,
   output logic [7:0]                rsp_byte_value,
   output logic                      rsp_link_up,
   output logic [SID_WIDTH-1:0]      rsp_session_id,
   output logic                      rsp_session_reset,
   output logic [1:0]                rsp_line_error
);

   held_item_type item;
   result_type    result;
   result_type    rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          advance;
   logic          fire;

   // result register can take a new transaction when empty or draining
   assign advance = !rsp_valid_ff || !rsp_stall;
   // held character moves through the parser this cycle
   assign fire    = item.valid && advance;

   tllr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_char (req_rx_char),
      .advance     (advance),
      .req_stall   (req_stall),
      .item        (item)
   );

   // parse state only moves when a character fires
   tllr_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_char (item.rx_char),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // result register: control reset, payload loads on fire
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_valid    = rsp_ff.byte_valid;
   assign rsp_byte_value    = rsp_ff.byte_value;
   assign rsp_link_up       = rsp_ff.link_up;
   assign rsp_session_id    = rsp_ff.session_id;
   assign rsp_session_reset = rsp_ff.session_reset;
   assign rsp_line_error    = rsp_ff.line_error;

   // a data byte only goes out while the link is up
   `TLLR_ASSERT_NOW(a_byte_needs_link, clock, reset, rsp_valid && rsp_byte_valid, rsp_link_up)
   // id reads zero whenever the link is down
   `TLLR_ASSERT_NOW(a_id_zero_down, clock, reset, rsp_valid && !rsp_link_up, rsp_session_id == '0)
   // an errored line neither delivers a byte nor changes the link
   `TLLR_ASSERT_NOW(a_err_no_effect, clock, reset, rsp_valid && (rsp_line_error != ERR_NONE), !rsp_byte_valid && !rsp_session_reset)
   // input side only backs up behind a full, stalled result register
   `TLLR_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // a fired character always shows up as a result next cycle
   `TLLR_ASSERT_NEXT(a_fire_result, clock, reset, fire, rsp_valid)

endmodule
`default_nettype wire

/* hdl/tllr_in_stage.sv */
`default_nettype none
module tllr_in_stage
   import tllr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [7:0]    req_rx_char,
   input  wire logic          advance,
   output logic               req_stall,
   output held_item_type      item
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         char_ff <= req_rx_char;
      end
   end

   assign item.valid   = valid_ff;
   assign item.rx_char = char_ff;

endmodule
`default_nettype wire

/* hdl/tllr_parse.sv */
`default_nettype none
module tllr_parse
   import tllr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] rx_char,
   output result_type      result
);

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_IGNORE = 2'd1,
      PH_TAG    = 2'd2
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                is_data_ff, is_data_in;
   logic [7:0]          first_ff, first_in;
   logic [7:0]          second_ff, second_in;
   logic [1:0]          held_ff, held_in;
   logic                conn_ff, conn_in;
   logic [ID_WIDTH-1:0] count_ff, count_in;
   logic [7:0]          flag;
   logic [4:0]          h1, h2;
   logic                byte_ok;
   logic [7:0]          byte_val;
   logic                sreset;
   line_error_type      err;

   always_comb begin
      phase_in   = phase_ff;
      is_data_in = is_data_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      held_in    = held_ff;
      conn_in    = conn_ff;
      count_in   = count_ff;
      byte_ok    = 1'b0;
      byte_val   = 8'd0;
      sreset     = 1'b0;
      err        = ERR_NONE;
      flag       = (held_ff != 2'd0) ? first_ff : 8'd0;
      h1         = (held_ff != 2'd0) ? hex_digit(first_ff) : 5'd0;
      h2         = (held_ff == 2'd2) ? hex_digit(second_ff) : 5'd0;
      if (fire) begin
         case (phase_ff)
            PH_IGNORE: begin
               if (rx_char == CH_LF) begin
                  phase_in = PH_START;
                  held_in  = 2'd0;
               end
            end
            PH_TAG: begin
               if (rx_char == CH_CR) begin
                  // carriage return inside a tag line is dropped
               end else if (rx_char == CH_LF) begin
                  if (!is_data_ff) begin
                     if (flag != CH_ZERO && flag != CH_ONE) begin
                        err = ERR_STATUS;
                     end else if (flag == CH_ONE && !conn_ff) begin
                        conn_in  = 1'b1;
                        count_in = count_ff + {{(ID_WIDTH-1){1'b0}}, 1'b1};
                        sreset   = 1'b1;
                     end else if (flag == CH_ZERO && conn_ff) begin
                        conn_in = 1'b0;
                        sreset  = 1'b1;
                     end
                  end else if (conn_ff) begin
                     if (h1[4] && h2[4]) begin
                        byte_ok  = 1'b1;
                        byte_val = {h1[3:0], h2[3:0]};
                     end else begin
                        err = ERR_DATA;
                     end
                  end
                  phase_in   = PH_START;
                  is_data_in = 1'b0;
                  held_in    = 2'd0;
               end else if (held_ff == 2'd0) begin
                  first_in = rx_char;
                  held_in  = 2'd1;
               end else if (held_ff == 2'd1) begin
                  second_in = rx_char;
                  held_in   = 2'd2;
               end
            end
            default: begin
               phase_in   = PH_START;
               is_data_in = 1'b0;
               held_in    = 2'd0;
               if (rx_char == CH_PROMPT || rx_char == CH_SPACE ||
                   rx_char == CH_CR || rx_char == CH_LF) begin
                  // leading filler skipped
               end else if (rx_char == CH_BANG || rx_char == CH_PLUS) begin
                  phase_in   = PH_TAG;
                  is_data_in = (rx_char == CH_PLUS);
               end else begin
                  phase_in = PH_IGNORE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         is_data_ff <= 1'b0;
         held_ff    <= 2'd0;
         conn_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         is_data_ff <= is_data_in;
         held_ff    <= held_in;
         conn_ff    <= conn_in;
         count_ff   <= count_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign result.byte_valid    = byte_ok;
   assign result.byte_value    = byte_val;
   assign result.link_up       = conn_in;
   assign result.session_id    = conn_in ? SID_WIDTH'(count_in) : '0;
   assign result.session_reset = sreset;
   assign result.line_error    = err;

endmodule
`default_nettype wire
